// File: hdl/sts_pkg.sv
// Shared types and constants of the source token scanner.
package sts_pkg;

    typedef logic [5:0] t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
    } t_tok;

    localparam t_kind K_PLUS     = 6'd0;
    localparam t_kind K_MINUS    = 6'd1;
    localparam t_kind K_STAR     = 6'd2;
    localparam t_kind K_SLASH    = 6'd3;
    localparam t_kind K_LPAREN   = 6'd4;
    localparam t_kind K_RPAREN   = 6'd5;
    localparam t_kind K_LBRACE   = 6'd6;
    localparam t_kind K_RBRACE   = 6'd7;
    localparam t_kind K_SEMI     = 6'd8;
    localparam t_kind K_COMMA    = 6'd9;
    localparam t_kind K_ASSIGN   = 6'd10;
    localparam t_kind K_BANG     = 6'd12;
    localparam t_kind K_LESS     = 6'd14;
    localparam t_kind K_GREATER  = 6'd16;
    localparam t_kind K_STRING   = 6'd18;
    localparam t_kind K_NEWLINE  = 6'd19;
    localparam t_kind K_NUMBER   = 6'd20;
    localparam t_kind K_IDENT    = 6'd21;
    localparam t_kind K_KEYWORD0 = 6'd22;
    localparam t_kind K_UNKNOWN  = 6'd34;
    localparam t_kind K_EOF      = 6'd35;

    localparam int KW_COUNT = 12;

    // Keyword text, right aligned, in the order of their token kinds.
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'("let"), 48'("print"), 48'("if"), 48'("else"), 48'("while"), 48'("true"),
        48'("false"), 48'("input"), 48'("and"), 48'("or"), 48'("fn"), 48'("return")
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5, 3'd3, 3'd2, 3'd2, 3'd6
    };

endpackage

// File: hdl/source_token_scanner.sv
// Byte stream lexical scanner that emits one token item per output handshake.
//
// Channel   Dir  Payload
// s_axis    in   tdata: byte_value; tuser: has_byte; tlast: end_of_source
// m_axis    out  tdata: token_start, token_length, line_number; tuser: token_kind;
//                tlast: last_result
//
// A byte item enters the input register, and once the result buffer is free one
// pass of logic scans it and loads up to three tokens into the result buffer.
// Items that give at most one token sustain one item per clock.
// An item with two or three tokens holds the input while the result buffer drains;
// a stalled output stalls the input the same way.
// Synchronous active-low reset returns the scanner to the start of a new source.
module source_token_scanner #(
    parameter int POSITION_BITS     = 16,
    parameter int KEYWORD_MAX_CHARS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_value
    input  logic [0:0]  s_axis_tuser,   // has_byte
    input  logic        s_axis_tlast,   // end_of_source
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // token_start, token_length, line_number
    output logic [5:0]  m_axis_tuser,   // token_kind
    output logic        m_axis_tlast    // last_result
);
    import sts_pkg::*;

    localparam int WB = 8 * KEYWORD_MAX_CHARS;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_HELD    = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_NUMBER  = 3'd3;
    localparam logic [2:0] MODE_IDENT   = 3'd4;
    localparam logic [2:0] MODE_STRING  = 3'd5;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [POSITION_BITS-1:0] span(input logic [POSITION_BITS-1:0] from,
                                                      input logic [POSITION_BITS-1:0] to);
        return (to > from) ? to - from : '0;
    endfunction

    function automatic t_kind ident_kind(input logic [POSITION_BITS-1:0] len,
                                         input logic [WB-1:0] win);
        t_kind kind;
        kind = K_IDENT;
        if (len <= POSITION_BITS'(KEYWORD_MAX_CHARS)) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                if (len == POSITION_BITS'(KW_LEN[k]) && win == WB'(KW_TEXT[k])) begin
                    kind = K_KEYWORD0 + t_kind'(k);
                end
            end
        end
        return kind;
    endfunction

    function automatic t_tok mk_tok(input t_kind kind, input logic [POSITION_BITS-1:0] start,
                                    input logic [POSITION_BITS-1:0] len,
                                    input logic [15:0] line);
        t_tok t;
        t.kind   = kind;
        t.start  = 16'(start);
        t.length = 16'(len);
        t.line   = line;
        return t;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // Input register.
    logic                     r_in_valid;
    logic [7:0]               r_in_byte;
    logic                     r_in_has;
    logic                     r_in_end;

    // Scanner state.
    logic [2:0]               r_mode;
    t_kind                    r_held;
    logic [POSITION_BITS-1:0] r_ls;
    logic [POSITION_BITS-1:0] r_pos;
    logic [15:0]              r_line;
    logic [WB-1:0]            r_win;

    // Result buffer.
    t_tok                     r_tok [3];
    logic [1:0]               r_cnt;
    logic [1:0]               r_idx;

    logic                     out_fire;
    logic                     buf_free;
    logic                     proc_fire;

    logic [2:0]               n_mode;
    t_kind                    n_held;
    logic [POSITION_BITS-1:0] n_ls;
    logic [POSITION_BITS-1:0] n_pos;
    logic [15:0]              n_line;
    logic [WB-1:0]            n_win;
    t_tok                     n_tok [3];
    logic [1:0]               n_cnt;

    assign m_axis_tvalid = (r_idx != r_cnt);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign buf_free      = !m_axis_tvalid || (out_fire && (r_idx + 2'd1 == r_cnt));
    assign proc_fire     = r_in_valid && buf_free;
    assign s_axis_tready = !r_in_valid || proc_fire;

    assign m_axis_tuser  = r_tok[r_idx].kind;
    assign m_axis_tdata  = {r_tok[r_idx].line, r_tok[r_idx].length, r_tok[r_idx].start};
    assign m_axis_tlast  = (r_idx + 2'd1 == r_cnt);

    always_comb begin
        logic                     fresh;
        logic [POSITION_BITS-1:0] pos;
        logic [POSITION_BITS-1:0] s;
        logic [POSITION_BITS-1:0] len;
        logic [7:0]               c;
        n_mode = r_mode;
        n_held = r_held;
        n_ls   = r_ls;
        n_pos  = r_pos;
        n_line = r_line;
        n_win  = r_win;
        n_cnt  = 2'd0;
        fresh  = 1'b0;
        c      = r_in_byte;
        pos    = r_pos;
        s      = '0;
        len    = '0;
        for (int i = 0; i < 3; i++) begin
            n_tok[i] = r_tok[i];
        end

        if (r_in_has) begin
            n_pos = sat_inc(r_pos);
            unique case (r_mode)
                MODE_HELD: begin
                    n_mode = MODE_IDLE;
                    if (r_held == K_SLASH && c == "/") begin
                        n_mode = MODE_COMMENT;
                    end else if (r_held != K_SLASH && c == "=") begin
                        n_tok[n_cnt] = mk_tok(r_held + 6'd1, r_ls, POSITION_BITS'(2), n_line);
                        n_cnt = n_cnt + 2'd1;
                    end else begin
                        n_tok[n_cnt] = mk_tok(r_held, r_ls, POSITION_BITS'(1), n_line);
                        n_cnt = n_cnt + 2'd1;
                        fresh = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (c == "\n") begin
                        n_mode = MODE_IDLE;
                        fresh  = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (!is_digit(c)) begin
                        n_mode = MODE_IDLE;
                        n_tok[n_cnt] = mk_tok(K_NUMBER, r_ls, span(r_ls, pos), n_line);
                        n_cnt = n_cnt + 2'd1;
                        fresh = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        n_win = {r_win[WB-9:0], c};
                    end else begin
                        n_mode = MODE_IDLE;
                        n_tok[n_cnt] = mk_tok(ident_kind(span(r_ls, pos), r_win), r_ls,
                                              span(r_ls, pos), n_line);
                        n_cnt = n_cnt + 2'd1;
                        fresh = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (c == "\"") begin
                        s = sat_inc(r_ls);
                        n_mode = MODE_IDLE;
                        n_tok[n_cnt] = mk_tok(K_STRING, s, span(s, pos), n_line);
                        n_cnt = n_cnt + 2'd1;
                    end else if (c == "\n" && n_line != 16'hFFFF) begin
                        n_line = n_line + 16'd1;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                    fresh  = 1'b1;
                end
            endcase

            if (fresh) begin
                n_ls = pos;
                priority if (c == "+" || c == "-" || c == "*" || c == "(" || c == ")" ||
                             c == "{" || c == "}" || c == ";" || c == ",") begin
                    unique case (c)
                        "+":     n_tok[n_cnt] = mk_tok(K_PLUS, pos, POSITION_BITS'(1), n_line);
                        "-":     n_tok[n_cnt] = mk_tok(K_MINUS, pos, POSITION_BITS'(1), n_line);
                        "*":     n_tok[n_cnt] = mk_tok(K_STAR, pos, POSITION_BITS'(1), n_line);
                        "(":     n_tok[n_cnt] = mk_tok(K_LPAREN, pos, POSITION_BITS'(1), n_line);
                        ")":     n_tok[n_cnt] = mk_tok(K_RPAREN, pos, POSITION_BITS'(1), n_line);
                        "{":     n_tok[n_cnt] = mk_tok(K_LBRACE, pos, POSITION_BITS'(1), n_line);
                        "}":     n_tok[n_cnt] = mk_tok(K_RBRACE, pos, POSITION_BITS'(1), n_line);
                        ";":     n_tok[n_cnt] = mk_tok(K_SEMI, pos, POSITION_BITS'(1), n_line);
                        default: n_tok[n_cnt] = mk_tok(K_COMMA, pos, POSITION_BITS'(1), n_line);
                    endcase
                    n_cnt = n_cnt + 2'd1;
                end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "/") begin
                    unique case (c)
                        "=":     n_held = K_ASSIGN;
                        "!":     n_held = K_BANG;
                        "<":     n_held = K_LESS;
                        ">":     n_held = K_GREATER;
                        default: n_held = K_SLASH;
                    endcase
                    n_mode = MODE_HELD;
                end else if (c == "\"") begin
                    n_mode = MODE_STRING;
                end else if (c == " " || c == "\t" || c == "\r") begin
                    n_mode = MODE_IDLE;
                end else if (c == "\n") begin
                    n_tok[n_cnt] = mk_tok(K_NEWLINE, pos, POSITION_BITS'(1), n_line);
                    n_cnt = n_cnt + 2'd1;
                    if (n_line != 16'hFFFF) begin
                        n_line = n_line + 16'd1;
                    end
                end else if (is_digit(c)) begin
                    n_mode = MODE_NUMBER;
                end else if (is_alpha(c)) begin
                    n_win  = WB'(c);
                    n_mode = MODE_IDENT;
                end else begin
                    n_tok[n_cnt] = mk_tok(K_UNKNOWN, pos, POSITION_BITS'(1), n_line);
                    n_cnt = n_cnt + 2'd1;
                end
            end
        end

        if (r_in_end) begin
            len = span(n_ls, n_pos);
            unique case (n_mode)
                MODE_HELD: begin
                    n_tok[n_cnt] = mk_tok(n_held, n_ls, POSITION_BITS'(1), n_line);
                    n_cnt = n_cnt + 2'd1;
                end
                MODE_NUMBER: begin
                    n_tok[n_cnt] = mk_tok(K_NUMBER, n_ls, len, n_line);
                    n_cnt = n_cnt + 2'd1;
                end
                MODE_IDENT: begin
                    n_tok[n_cnt] = mk_tok(ident_kind(len, n_win), n_ls, len, n_line);
                    n_cnt = n_cnt + 2'd1;
                end
                MODE_STRING: begin
                    n_tok[n_cnt] = mk_tok(K_UNKNOWN, n_ls, len, n_line);
                    n_cnt = n_cnt + 2'd1;
                end
                default: begin
                    n_cnt = n_cnt;
                end
            endcase
            n_tok[n_cnt] = mk_tok(K_EOF, n_pos, '0, n_line);
            n_cnt  = n_cnt + 2'd1;
            n_mode = MODE_IDLE;
            n_held = '0;
            n_ls   = '0;
            n_pos  = '0;
            n_line = 16'd1;
            n_win  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_held     <= '0;
            r_ls       <= '0;
            r_pos      <= '0;
            r_line     <= 16'd1;
            r_win      <= '0;
            r_cnt      <= 2'd0;
            r_idx      <= 2'd0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end
            if (proc_fire) begin
                r_mode <= n_mode;
                r_held <= n_held;
                r_ls   <= n_ls;
                r_pos  <= n_pos;
                r_line <= n_line;
                r_win  <= n_win;
                r_cnt  <= n_cnt;
                r_idx  <= 2'd0;
            end else if (out_fire) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_has  <= s_axis_tuser[0];
            r_in_end  <= s_axis_tlast;
        end
        if (proc_fire) begin
            for (int i = 0; i < 3; i++) begin
                r_tok[i] <= n_tok[i];
            end
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_cnt)
        else $error("Result index passed the result count.");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != 16'd0)
        else $error("Line count reached zero.");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_in_end |-> n_cnt != 2'd0 && n_tok[n_cnt - 2'd1].kind == K_EOF)
        else $error("End of source did not close with an end token.");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_in_end |=> r_mode == MODE_IDLE && r_pos == '0 && r_line == 16'd1)
        else $error("Scanner state not cleared after end of source.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire |-> !m_axis_tvalid || m_axis_tlast)
        else $error("Result buffer reloaded while results were pending.");

endmodule
